>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/met_pkg.sv
// Constants, types and command/status structs of the escape-time pixel engine.
package met_pkg;

    // Image size in pixels
    localparam int IMAGE_WIDTH  = 600;
    localparam int IMAGE_HEIGHT = 600;

    localparam int PIX_W     = 10;
    localparam int Z_W       = 32;
    localparam int PROD_W    = 2 * Z_W;
    localparam int WIDE_W    = PROD_W + 2;
    localparam int FRAC_BITS = 28;
    localparam int CNT_W     = 16;
    localparam int ESC_BIT   = 2 * FRAC_BITS + 2;   // 4.0 in Q8.56

    // Coordinate map: q = floor(p * 2^30 / size) = 4*p/size in Q2.28, by a
    // reciprocal multiply. The shift is wide enough that q is exact for every
    // p < size <= 1024.
    localparam int Q_W         = FRAC_BITS + 2;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = Q_W + RECIP_SHIFT;
    localparam int PROD_C_W    = RECIP_W + PIX_W;
    localparam logic [RECIP_W-1:0] RECIP_X =
        RECIP_W'(((64'd1 << RECIP_W) + 64'(IMAGE_WIDTH - 1)) / 64'(IMAGE_WIDTH));
    localparam logic [RECIP_W-1:0] RECIP_Y =
        RECIP_W'(((64'd1 << RECIP_W) + 64'(IMAGE_HEIGHT - 1)) / 64'(IMAGE_HEIGHT));

    localparam logic [PIX_W:0] IMG_W_C = (PIX_W + 1)'(IMAGE_WIDTH);
    localparam logic [PIX_W:0] IMG_H_C = (PIX_W + 1)'(IMAGE_HEIGHT);

    // c = q - 2.0
    localparam logic signed [Z_W-1:0] C_OFFSET = Z_W'(2) <<< FRAC_BITS;

    localparam logic [CNT_W-1:0] MAX_ITERS_RESET = CNT_W'(10000);

    localparam int RED_W   = 4;
    localparam int GREEN_W = 5;
    localparam int BLUE_W  = 6;
    localparam logic [RED_W-1:0]   RED_LAST   = RED_W'(10);
    localparam logic [GREEN_W-1:0] GREEN_LAST = GREEN_W'(20);
    localparam logic [BLUE_W-1:0]  BLUE_LAST  = BLUE_W'(50);

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 2;

    typedef struct packed {
        logic load;       // latch pixel, clear iterate
        logic div_step;   // map both pixel coordinates to c
        logic mul;        // register the three products
        logic upd;        // take one iteration step
        logic out_load;   // move the finished item to the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic stop;       // iterate has finished
        logic out_free;   // output register can take an item this cycle
    } ctrl_sts_t;

endpackage

>>> src/met_ctrl.sv
// Sequencer for the escape-time pixel engine: map, iterate, hand off.
module met_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  met_pkg::ctrl_sts_t sts,
    output met_pkg::ctrl_cmd_t cmd
);
    import met_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!sts.in_range) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.div_step = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (sts.stop) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.upd    = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/met_dp.sv
// Datapath: coordinate map, complex iterate, colour counters, output register.
module met_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [met_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              cfg_wr,
    input  logic [met_pkg::CNT_W-1:0]         cfg_data,
    input  met_pkg::ctrl_cmd_t                cmd,
    output met_pkg::ctrl_sts_t                sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [met_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [met_pkg::M_USER_W-1:0]      m_tuser
);
    import met_pkg::*;

    logic [CNT_W-1:0] max_reg;

    // coordinate map
    logic [PIX_W-1:0]    pix_x_reg, pix_y_reg;
    logic [Q_W-1:0]      q_x_reg, q_y_reg;
    logic [PROD_C_W-1:0] prod_x, prod_y;
    logic                in_range_reg;
    logic [PIX_W-1:0]    px, py;

    // iterate
    logic signed [Z_W-1:0]    zx_reg, zy_reg, cx, cy;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, xy_reg;
    logic signed [PROD_W:0]   diff;
    logic signed [WIDE_W-1:0] diff_w, xy_w, nx_wide, ny_wide;
    logic signed [Z_W-1:0]    nx, ny;
    logic [PROD_W:0]          mag;
    logic                     esc;
    logic [CNT_W-1:0]         cnt_reg;
    logic [RED_W-1:0]         red_reg;
    logic [GREEN_W-1:0]       green_reg;
    logic [BLUE_W-1:0]        blue_reg;
    logic                     escaped;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;

    assign px = s_tdata[PIX_W-1:0];
    assign py = s_tdata[2*PIX_W-1:PIX_W];

    // floor(p * 2^30 / size) by multiplying with the rounded-up reciprocal
    assign prod_x = PROD_C_W'(pix_x_reg) * PROD_C_W'(RECIP_X);
    assign prod_y = PROD_C_W'(pix_y_reg) * PROD_C_W'(RECIP_Y);

    assign cx = $signed(Z_W'(q_x_reg)) - C_OFFSET;
    assign cy = $signed(Z_W'(q_y_reg)) - C_OFFSET;

    // floor shift, add c, saturate to 32 bits
    always_comb begin
        diff    = (PROD_W + 1)'(xx_reg) - (PROD_W + 1)'(yy_reg);
        diff_w  = WIDE_W'(diff);
        xy_w    = WIDE_W'(xy_reg);
        nx_wide = (diff_w >>> FRAC_BITS) + WIDE_W'(cx);
        ny_wide = (xy_w >>> (FRAC_BITS - 1)) + WIDE_W'(cy);
        if (!nx_wide[WIDE_W-1] && (|nx_wide[WIDE_W-2:Z_W-1])) begin
            nx = {1'b0, {(Z_W-1){1'b1}}};
        end else if (nx_wide[WIDE_W-1] && !(&nx_wide[WIDE_W-2:Z_W-1])) begin
            nx = {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            nx = nx_wide[Z_W-1:0];
        end
        if (!ny_wide[WIDE_W-1] && (|ny_wide[WIDE_W-2:Z_W-1])) begin
            ny = {1'b0, {(Z_W-1){1'b1}}};
        end else if (ny_wide[WIDE_W-1] && !(&ny_wide[WIDE_W-2:Z_W-1])) begin
            ny = {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            ny = ny_wide[Z_W-1:0];
        end
    end

    // |z|^2 of the current z, from the registered squares
    assign mag = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign esc = |mag[PROD_W:ESC_BIT];

    assign sts.in_range = in_range_reg;
    assign sts.stop     = (cnt_reg != '0) && ((cnt_reg >= max_reg) || esc);
    assign sts.out_free = !m_valid_reg || m_tready;

    assign escaped = in_range_reg && (cnt_reg < max_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_x_reg    <= px;
            pix_y_reg    <= py;
            in_range_reg <= ({1'b0, px} < IMG_W_C) && ({1'b0, py} < IMG_H_C);
            zx_reg       <= '0;
            zy_reg       <= '0;
            cnt_reg      <= '0;
            red_reg      <= '0;
            green_reg    <= '0;
            blue_reg     <= '0;
        end
        if (cmd.div_step) begin
            q_x_reg <= prod_x[RECIP_SHIFT +: Q_W];
            q_y_reg <= prod_y[RECIP_SHIFT +: Q_W];
        end
        if (cmd.mul) begin
            xx_reg <= zx_reg * zx_reg;
            yy_reg <= zy_reg * zy_reg;
            xy_reg <= zx_reg * zy_reg;
        end
        if (cmd.upd) begin
            zx_reg    <= nx;
            zy_reg    <= ny;
            cnt_reg   <= cnt_reg + 1'b1;
            red_reg   <= (red_reg == RED_LAST) ? '0 : red_reg + 1'b1;
            green_reg <= (green_reg == GREEN_LAST) ? '0 : green_reg + 1'b1;
            blue_reg  <= (blue_reg == BLUE_LAST) ? '0 : blue_reg + 1'b1;
        end
        if (cmd.out_load) begin
            m_user_reg <= {escaped, in_range_reg};
            m_data_reg <= {1'b0,
                           escaped ? blue_reg : '0,
                           escaped ? green_reg : '0,
                           escaped ? red_reg : '0,
                           in_range_reg ? cnt_reg : '0};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            max_reg     <= MAX_ITERS_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                max_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> src/mandelbrot_escape_time_pixel_top.sv
// Top level of the Mandelbrot escape-time pixel engine.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------------
//  s_      | in  | s_tvalid / s_tready      | s_tdata: pixel_x, pixel_y
//  m_      | out | m_tvalid / m_tready      | m_tdata: iterations, levels
//          |     |                          | m_tuser: in_range, escaped
//  cfg_    | in  | cfg_valid / cfg_ready    | cfg_data: max_iters
//
// An in-range item passes through acceptance, the map of the pixel to c (reciprocal
// multiply), per iteration the multiply stage (products) and update stage (z step), one
// more multiply and update pass for the final escape test, and the load of the output
// register, which waits while that register is full. An out-of-range item skips the
// map and iterate and goes straight to that load. One item is in work at a time. A
// finished item waits in the output register, so the next item is accepted while
// m_tready is low. Reset (aresetn low, synchronous) drops any item in flight and
// restores max_iters to 10000. cfg_ready is always high; write only while idle.
module mandelbrot_escape_time_pixel_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [met_pkg::S_DATA_W-1:0] s_tdata,   // [9:0] pixel_x, [19:10] pixel_y
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] iterations, [19:16] red_level, [24:20] green_level, [30:25] blue_level
    output logic [met_pkg::M_DATA_W-1:0] m_tdata,
    output logic [met_pkg::M_USER_W-1:0] m_tuser,   // [0] in_range, [1] escaped
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [met_pkg::CNT_W-1:0]    cfg_data   // max_iters
);
    import met_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Configuration is to be written only while idle; the block does not enforce it, so always take it.
    assign cfg_ready = 1'b1;

    met_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    met_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cfg_wr   (cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> src/met_checker.sv
// Port-level checker for the escape-time pixel engine, bound to the top level.
`include "assert_macros.svh"

module met_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [met_pkg::M_DATA_W-1:0] m_tdata,
    input logic [met_pkg::M_USER_W-1:0] m_tuser
);
    import met_pkg::*;

    // Hold a stalled item.
    `AST_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Out-of-range items carry all-zero fields.
    `AST_IMPLY(a_oor_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0 && !m_tuser[1])

    // In-range items run at least one iteration.
    `AST_IMPLY(a_min_iter, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[15:0] != '0)

    // Points that did not escape are black.
    `AST_IMPLY(a_black, aclk, aresetn, m_tvalid && !m_tuser[1], m_tdata[30:16] == '0)

    // Colour levels stay below their moduli.
    `AST_IMPLY(a_levels, aclk, aresetn, m_tvalid, (m_tdata[19:16] <= RED_LAST) && (m_tdata[24:20] <= GREEN_LAST) && (m_tdata[30:25] <= BLUE_LAST) && !m_tdata[31])

endmodule

bind mandelbrot_escape_time_pixel_top met_checker u_met_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/tb_top.sv
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
`timescale 1ns / 100ps

module tb_top;
    import met_pkg::*;

    // Colour index moduli and the escape threshold 4.0 in Q8.56
    localparam int RED_MOD   = 11;
    localparam int GREEN_MOD = 21;
    localparam int BLUE_MOD  = 51;
    localparam longint unsigned ESCAPE_MAG = 64'd1 << ESC_BIT;
    localparam longint Z_MAX = 64'sd2147483647;
    localparam longint Z_MIN = -64'sd2147483648;

    localparam int DIR_ROWS     = 23;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 20;

    // One result item, unpacked from m_tuser / m_tdata
    typedef struct packed {
        logic              in_range;
        logic              escaped;
        logic [CNT_W-1:0]  iterations;
        logic [RED_W-1:0]  red;
        logic [GREEN_W-1:0] green;
        logic [BLUE_W-1:0] blue;
    } pixel_result_t;

    // Directed row: limit to run under, pixel, and a typed result where exact is set
    typedef struct packed {
        logic [CNT_W-1:0]   limit;
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic               exact;
        logic               in_range;
        logic               escaped;
        logic [CNT_W-1:0]   iterations;
        logic [RED_W-1:0]   red;
        logic [GREEN_W-1:0] green;
        logic [BLUE_W-1:0]  blue;
    } dir_row_t;

    // Directed stimulus, grouped by limit so that few register writes are needed
    dir_row_t dir_plan [DIR_ROWS] = '{
        // corner c = -2-2i leaves the disk at the first step
        '{16'd10000, 10'd0,    10'd0,    1'b1, 1'b1, 1'b1, 16'd1,     4'd1, 5'd1, 6'd1},
        // coordinates outside the image: all fields zero; the in-image far corner is predicted
        '{16'd10000, 10'd1023, 10'd1023, 1'b1, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd10000, 10'd600,  10'd0,    1'b1, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd10000, 10'd0,    10'd600,  1'b1, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd10000, 10'd599,  10'd599,  1'b0, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        // c = -2: |z|^2 lands exactly on 4 and counts as escaped
        '{16'd10000, 10'd0,    10'd300,  1'b1, 1'b1, 1'b1, 16'd1,     4'd1, 5'd1, 6'd1},
        // c = 0 and c = -1 never escape: black at the reset limit
        '{16'd10000, 10'd300,  10'd300,  1'b1, 1'b1, 1'b0, 16'd10000, 4'd0, 5'd0, 6'd0},
        '{16'd10000, 10'd150,  10'd300,  1'b1, 1'b1, 1'b0, 16'd10000, 4'd0, 5'd0, 6'd0},
        // c = 1 reaches |z| = 2 at the second step
        '{16'd200,   10'd450,  10'd300,  1'b1, 1'b1, 1'b1, 16'd2,     4'd2, 5'd2, 6'd2},
        '{16'd200,   10'd599,  10'd0,    1'b0, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd200,   10'd0,    10'd599,  1'b0, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd200,   10'd200,  10'd400,  1'b0, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd200,   10'd480,  10'd330,  1'b0, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd200,   10'd350,  10'd450,  1'b0, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd200,   10'd599,  10'd1023, 1'b1, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        '{16'd200,   10'd1023, 10'd599,  1'b1, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0},
        // reaching the limit does not count as escaped, even with an escape on the last allowed step
        '{16'd2,     10'd450,  10'd300,  1'b1, 1'b1, 1'b0, 16'd2,     4'd0, 5'd0, 6'd0},
        '{16'd1,     10'd300,  10'd300,  1'b1, 1'b1, 1'b0, 16'd1,     4'd0, 5'd0, 6'd0},
        '{16'd1,     10'd0,    10'd0,    1'b1, 1'b1, 1'b0, 16'd1,     4'd0, 5'd0, 6'd0},
        // a zero limit acts like one
        '{16'd0,     10'd300,  10'd300,  1'b1, 1'b1, 1'b0, 16'd1,     4'd0, 5'd0, 6'd0},
        '{16'd0,     10'd450,  10'd300,  1'b1, 1'b1, 1'b0, 16'd1,     4'd0, 5'd0, 6'd0},
        // full-scale limit
        '{16'd65535, 10'd300,  10'd300,  1'b1, 1'b1, 1'b0, 16'd65535, 4'd0, 5'd0, 6'd0},
        '{16'd65535, 10'd420,  10'd310,  1'b0, 1'b0, 1'b0, 16'd0,     4'd0, 5'd0, 6'd0}
    };

    // Clock and reset; every input starts at a known value
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data  = '0;

    always #1 aclk = ~aclk;

    mandelbrot_escape_time_pixel_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pixel_result_t    pending_pixels [$];   // predicted results, oldest first
    logic [CNT_W-1:0] cur_limit = MAX_ITERS_RESET;
    int               errors = 0;
    int               results_seen = 0;
    bit               idle_on = 1'b1;       // clear for stretches without gaps
    bit               holding = 1'b0;       // s_tvalid left high after the last item
    int               stall_left = 0;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > Z_MAX)
            return Z_MAX;
        if (v < Z_MIN)
            return Z_MIN;
        return v;
    endfunction

    // Escape-time predictor: Q4.28 iterate, exact Q8.56 products, floor on the shifts
    function automatic pixel_result_t escape_time_of(input logic [PIX_W-1:0] px,
                                                     input logic [PIX_W-1:0] py,
                                                     input logic [CNT_W-1:0] limit);
        pixel_result_t    r;
        longint unsigned  q;
        longint unsigned  mag;
        longint           cx, cy, zx, zy, xx, yy, xy, nx, ny;
        int unsigned      count;
        bit               esc;
        r = '0;
        if (px >= IMAGE_WIDTH || py >= IMAGE_HEIGHT)
            return r;
        q  = (64'(px) << (FRAC_BITS + 2)) / 64'(IMAGE_WIDTH);
        cx = longint'(q) - (64'sd2 <<< FRAC_BITS);
        q  = (64'(py) << (FRAC_BITS + 2)) / 64'(IMAGE_HEIGHT);
        cy = longint'(q) - (64'sd2 <<< FRAC_BITS);
        zx = 0;
        zy = 0;
        count = 0;
        do begin
            xx = zx * zx;
            yy = zy * zy;
            xy = zx * zy;
            nx = clamp32(((xx - yy) >>> FRAC_BITS) + cx);
            ny = clamp32((xy >>> (FRAC_BITS - 1)) + cy);
            zx = nx;
            zy = ny;
            count++;
            mag = longint'(zx * zx) + longint'(zy * zy);
        end while (count < limit && mag < ESCAPE_MAG);
        esc = count < limit;
        r.in_range   = 1'b1;
        r.escaped    = esc;
        r.iterations = count[CNT_W-1:0];
        if (esc) begin
            r.red   = RED_W'(count % RED_MOD);
            r.green = GREEN_W'(count % GREEN_MOD);
            r.blue  = BLUE_W'(count % BLUE_MOD);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Result side: check each accepted item against the oldest prediction,
    // then decide whether to stall the next cycle
    always @(posedge aclk) begin
        pixel_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.in_range   = m_tuser[0];
            got.escaped    = m_tuser[1];
            got.iterations = m_tdata[15:0];
            got.red        = m_tdata[19:16];
            got.green      = m_tdata[24:20];
            got.blue       = m_tdata[30:25];
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with no pixel pending");
            end else begin
                want = pending_pixels.pop_front();
                check_field("in_range",    got.in_range,   want.in_range);
                check_field("escaped",     got.escaped,    want.escaped);
                check_field("iterations",  got.iterations, want.iterations);
                check_field("red_level",   got.red,        want.red);
                check_field("green_level", got.green,      want.green);
                check_field("blue_level",  got.blue,       want.blue);
            end
            results_seen++;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Drop s_tvalid if it was left high, then hold until every result is in
    task automatic drain_pixels();
        if (holding) begin
            s_tvalid <= 1'b0;
            holding = 1'b0;
        end
        while (pending_pixels.size() != 0)
            @(posedge aclk);
    endtask

    // Write max_iters while the engine is idle and track it for the predictor
    task automatic write_max_iters(input logic [CNT_W-1:0] v);
        drain_pixels();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    // Send one pixel item; push the typed result when exact, else the prediction.
    // s_tvalid stays high after acceptance so back-to-back items need one assignment.
    task automatic issue_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                               input bit exact, input pixel_result_t want);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            if (holding) begin
                s_tvalid <= 1'b0;
                holding = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 2 * PIX_W){1'b0}}, py, px};
        do @(posedge aclk); while (!s_tready);
        holding = 1'b1;
        pending_pixels.push_back(exact ? want : escape_time_of(px, py, cur_limit));
    endtask

    // Stimulus: reset, directed table, then random phases under changing limits
    initial begin
        pixel_result_t    want;
        logic [PIX_W-1:0] px, py;
        logic [CNT_W-1:0] lim;
        int               mode;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_plan[i].limit != cur_limit)
                write_max_iters(dir_plan[i].limit);
            want.in_range   = dir_plan[i].in_range;
            want.escaped    = dir_plan[i].escaped;
            want.iterations = dir_plan[i].iterations;
            want.red        = dir_plan[i].red;
            want.green      = dir_plan[i].green;
            want.blue       = dir_plan[i].blue;
            issue_pixel(dir_plan[i].x, dir_plan[i].y, dir_plan[i].exact, want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                1:       lim = CNT_W'($urandom_range(1, 20));
                2:       lim = CNT_W'($urandom_range(1000, 2000));
                default: lim = CNT_W'($urandom_range(30, 400));
            endcase
            write_max_iters(lim);
            // run one phase back to back on both sides
            idle_on = (ph != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the sender until the engine has emptied once mid-phase
                if (ph == 0 && n == PHASE_ITEMS / 2)
                    drain_pixels();
                if ($urandom_range(0, 99) < 85) begin
                    px = PIX_W'($urandom_range(0, IMAGE_WIDTH - 1));
                    py = PIX_W'($urandom_range(0, IMAGE_HEIGHT - 1));
                end else begin
                    mode = $urandom_range(0, 2);
                    px = PIX_W'($urandom_range(0, 1023));
                    py = PIX_W'($urandom_range(0, 1023));
                    if (mode == 0)
                        px = PIX_W'($urandom_range(IMAGE_WIDTH, 1023));
                    else if (mode == 1)
                        py = PIX_W'($urandom_range(IMAGE_HEIGHT, 1023));
                end
                issue_pixel(px, py, 1'b0, '0);
            end
        end
        idle_on = 1'b1;

        // let trailing results and any stray output show up
        drain_pixels();
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/met_pkg.sv
src/met_ctrl.sv
src/met_dp.sv
src/mandelbrot_escape_time_pixel_top.sv
src/met_checker.sv
verif/tb_top.sv
